// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; they compile to nothing when SYNTH is defined.
// Both expect clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in a cycle, consequent in the next one.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared sizes, codes and the particle record of the particle pool.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

    localparam int PARTICLE_COUNT = 64;
    localparam int IDX_W          = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
    localparam int CNT_W          = $clog2(PARTICLE_COUNT + 1);
    localparam int WORD_W         = 32;
    localparam int COUNT_PORT_W   = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = 1'd1;

    localparam logic FUNC_SPAWN  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [1:0] KIND_SPAWN_OK   = 2'd0;
    localparam logic [1:0] KIND_SPAWN_FULL = 2'd1;
    localparam logic [1:0] KIND_POSITION   = 2'd2;
    localparam logic [1:0] KIND_EMPTY      = 2'd3;

    localparam logic [COUNT_PORT_W-1:0] MAX_COUNT_RESET = 7'd64;
    localparam logic [WORD_W-1:0]       LIFETIME_RESET  = 32'd327680;

    // one memory word per particle
    typedef struct packed {
        logic [WORD_W-1:0]        birth;
        logic [2:0][WORD_W-1:0]   pos;
        logic [2:0][WORD_W-1:0]   vel;
    } ppu_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppu_advance.sv =====
// ----------------------------------------------------------------------------
// ppu_advance
// One axis of the motion step: pos + floor(vel * dt / 2^16), saturated.
// Product registered on load; new position valid the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_advance (
    input  wire logic                               clk,
    input  wire logic                               load,
    input  wire logic signed [ppu_pkg::WORD_W-1:0]  pos,
    input  wire logic signed [ppu_pkg::WORD_W-1:0]  vel,
    input  wire logic        [ppu_pkg::WORD_W-1:0]  dt,
    output logic signed      [ppu_pkg::WORD_W-1:0]  new_pos
);

    localparam int W = ppu_pkg::WORD_W;

    logic signed [W:0]       vel_s;
    logic signed [W:0]       dt_s;
    logic signed [2*W+1:0]   prod_full;
    logic signed [2*W-1:0]   prod_reg;
    logic signed [W-1:0]     pos_reg;
    logic signed [2*W-17:0]  step;
    logic signed [2*W-16:0]  sum;

    assign vel_s     = {vel[W-1], vel};
    assign dt_s      = {1'b0, dt};
    assign prod_full = vel_s * dt_s;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_full[2*W-1:0];
            pos_reg  <= pos;
        end
    end

    // arithmetic shift gives the floor of the division
    assign step = prod_reg[2*W-1:16];
    assign sum  = {{(W-15){pos_reg[W-1]}}, pos_reg} + {step[2*W-17], step};

    always_comb
    begin
        if (!sum[2*W-16] && (sum[2*W-17:W-1] != '0))
            new_pos = {1'b0, {(W-1){1'b1}}};
        else if (sum[2*W-16] && (sum[2*W-17:W-1] != '1))
            new_pos = {1'b1, {(W-1){1'b0}}};
        else
            new_pos = sum[W-1:0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with spawn and Euler update, lifetime retirement by swap.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a word is taken on a clock edge with start high and
//    busy low. func selects spawn or update.
//  - Results come out one cycle each on strobe; they cannot be held off.
//    last marks the final result of a command.
//  - Config channel: cfg_ready is always high; write cfg_index/cfg_data
//    only while busy is low and no result is outstanding.
//  - Spawn: busy stays low, result the next cycle. Spawns may
//    run back to back.
//  - Update: walks the particle memory (one 224-bit word per particle,
//    single read and write port, registered read). A survivor passes
//    READ, EVAL and SUM (read, age check + multiply, add + write back), a
//    retired particle READ, EVAL and MOVE (read, check + read of the last
//    slot, move), or only READ and EVAL when it is itself the last slot;
//    a closing READ ends the walk.
//  - A survivor's result is held back until the next survivor or the end
//    of the walk, so last can be set on it.
//  - Reset clears the live count and restores max_count 64, lifetime 5.0 s;
//    the memory is not cleared, only slots below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module particle_pool_update (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   func,
    input  wire logic        [31:0]                     now,
    input  wire logic        [31:0]                     time_step,
    input  wire logic signed [31:0]                     pos_x,
    input  wire logic signed [31:0]                     pos_y,
    input  wire logic signed [31:0]                     pos_z,
    input  wire logic signed [31:0]                     vel_x,
    input  wire logic signed [31:0]                     vel_y,
    input  wire logic signed [31:0]                     vel_z,

    output logic                                        strobe,
    output logic             [1:0]                      kind,
    output logic signed      [31:0]                     out_x,
    output logic signed      [31:0]                     out_y,
    output logic signed      [31:0]                     out_z,
    output logic             [ppu_pkg::COUNT_PORT_W-1:0] live_count,
    output logic                                        last,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [ppu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic        [31:0]                     cfg_data
);

    localparam int IDX_W = ppu_pkg::IDX_W;
    localparam int CNT_W = ppu_pkg::CNT_W;
    localparam int CPW   = ppu_pkg::COUNT_PORT_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_MOVE = 5'b01000,
        ST_SUM  = 5'b10000
    } state_t;

    // control
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic              strobe_reg,    strobe_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CPW-1:0]    max_count_reg;
    logic [31:0]       lifetime_reg;

    // payload
    logic [1:0]        kind_reg,      kind_next;
    logic [31:0]       ox_reg,        ox_next;
    logic [31:0]       oy_reg,        oy_next;
    logic [31:0]       oz_reg,        oz_next;
    logic [CPW-1:0]    live_reg,      live_next;
    logic              last_reg,      last_next;
    logic [31:0]       px_reg,        px_next;
    logic [31:0]       py_reg,        py_next;
    logic [31:0]       pz_reg,        pz_next;
    logic [CPW-1:0]    plive_reg,     plive_next;
    logic [31:0]       now_reg;
    logic [31:0]       dt_reg;
    ppu_pkg::ppu_rec_t cur_reg;

    // particle memory
    ppu_pkg::ppu_rec_t mem [ppu_pkg::PARTICLE_COUNT];
    ppu_pkg::ppu_rec_t rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ppu_pkg::ppu_rec_t wr_data;

    logic              accept;
    logic [CPW-1:0]    limit;
    logic [CPW-1:0]    cnt_ext;
    logic [CNT_W-1:0]  cnt_m1;
    logic [31:0]       age;
    logic              dead;
    logic              lane_load;
    logic signed [31:0] new_x, new_y, new_z;
    ppu_pkg::ppu_rec_t spawn_rec;
    ppu_pkg::ppu_rec_t upd_rec;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign cnt_ext = CPW'(cnt_reg);
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    // a limit above the pool depth acts as the depth
    assign limit   = (max_count_reg > CPW'(ppu_pkg::PARTICLE_COUNT)) ?
                     CPW'(ppu_pkg::PARTICLE_COUNT) : max_count_reg;

    // age wraps; lifetime zero retires everything
    assign age  = now_reg - rd_data_reg.birth;
    assign dead = (age >= lifetime_reg);

    always_comb
    begin
        spawn_rec.birth  = now;
        spawn_rec.pos[0] = pos_x;
        spawn_rec.pos[1] = pos_y;
        spawn_rec.pos[2] = pos_z;
        spawn_rec.vel[0] = vel_x;
        spawn_rec.vel[1] = vel_y;
        spawn_rec.vel[2] = vel_z;
    end

    always_comb
    begin
        upd_rec        = cur_reg;
        upd_rec.pos[0] = new_x;
        upd_rec.pos[1] = new_y;
        upd_rec.pos[2] = new_z;
    end

    ppu_advance u_adv_x (
        .clk     (clk),
        .load    (lane_load),
        .pos     (rd_data_reg.pos[0]),
        .vel     (rd_data_reg.vel[0]),
        .dt      (dt_reg),
        .new_pos (new_x)
    );

    ppu_advance u_adv_y (
        .clk     (clk),
        .load    (lane_load),
        .pos     (rd_data_reg.pos[1]),
        .vel     (rd_data_reg.vel[1]),
        .dt      (dt_reg),
        .new_pos (new_y)
    );

    ppu_advance u_adv_z (
        .clk     (clk),
        .load    (lane_load),
        .pos     (rd_data_reg.pos[2]),
        .vel     (rd_data_reg.vel[2]),
        .dt      (dt_reg),
        .new_pos (new_z)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        strobe_next     = 1'b0;
        pend_valid_next = pend_valid_reg;
        kind_next       = kind_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        oz_next         = oz_reg;
        live_next       = live_reg;
        last_next       = last_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pz_next         = pz_reg;
        plive_next      = plive_reg;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;
        lane_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == ppu_pkg::FUNC_SPAWN)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        ox_next     = '0;
                        oy_next     = '0;
                        oz_next     = '0;
                        if (cnt_ext < limit)
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = cnt_reg[IDX_W-1:0];
                            wr_data   = spawn_rec;
                            cnt_next  = cnt_reg + CNT_W'(1);
                            kind_next = ppu_pkg::KIND_SPAWN_OK;
                            live_next = CPW'(cnt_reg + CNT_W'(1));
                        end
                        else
                        begin
                            kind_next = ppu_pkg::KIND_SPAWN_FULL;
                            live_next = cnt_ext;
                        end
                    end
                    else
                    begin
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    // walk done: flush the held result or report empty
                    strobe_next     = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        kind_next = ppu_pkg::KIND_POSITION;
                        ox_next   = px_reg;
                        oy_next   = py_reg;
                        oz_next   = pz_reg;
                        live_next = plive_reg;
                    end
                    else
                    begin
                        kind_next = ppu_pkg::KIND_EMPTY;
                        ox_next   = '0;
                        oy_next   = '0;
                        oz_next   = '0;
                        live_next = cnt_ext;
                    end
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                // fetch the last slot in case this one retires
                rd_addr = cnt_m1[IDX_W-1:0];
                if (dead)
                begin
                    if (idx_reg == cnt_m1)
                    begin
                        cnt_next   = cnt_m1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_MOVE;
                    end
                end
                else
                begin
                    lane_load  = 1'b1;
                    state_next = ST_SUM;
                end
            end

            ST_MOVE:
            begin
                // last particle takes this slot; re-examined next
                wr_en      = 1'b1;
                wr_data    = rd_data_reg;
                cnt_next   = cnt_m1;
                state_next = ST_READ;
            end

            ST_SUM:
            begin
                wr_en   = 1'b1;
                wr_data = upd_rec;
                if (pend_valid_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b0;
                    kind_next   = ppu_pkg::KIND_POSITION;
                    ox_next     = px_reg;
                    oy_next     = py_reg;
                    oz_next     = pz_reg;
                    live_next   = plive_reg;
                end
                pend_valid_next = 1'b1;
                px_next         = new_x;
                py_next         = new_y;
                pz_next         = new_z;
                plive_next      = cnt_ext;
                idx_next        = idx_reg + CNT_W'(1);
                state_next      = ST_READ;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            strobe_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            max_count_reg  <= ppu_pkg::MAX_COUNT_RESET;
            lifetime_reg   <= ppu_pkg::LIFETIME_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            strobe_reg     <= strobe_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ppu_pkg::CFG_MAX_COUNT: max_count_reg <= cfg_data[CPW-1:0];
                    ppu_pkg::CFG_LIFETIME:  lifetime_reg  <= cfg_data;
                    default:                lifetime_reg  <= lifetime_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        live_reg  <= live_next;
        last_reg  <= last_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        plive_reg <= plive_next;
        if (accept)
        begin
            now_reg <= now;
            dt_reg  <= time_step;
        end
        if (state_reg == ST_EVAL)
            cur_reg <= rd_data_reg;
    end

    // particle memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_z      = oz_reg;
    assign live_count = live_reg;
    assign last       = last_reg;

    `ASSERT_ALWAYS(a_cnt_in_range, cnt_reg <= CNT_W'(ppu_pkg::PARTICLE_COUNT), "live count above pool depth")
    `ASSERT_ALWAYS(a_move_not_last, (state_reg != ST_MOVE) || (idx_reg < cnt_m1), "move into slot at or past the last")
    `ASSERT_NEXT(a_walk_no_growth, state_reg != ST_IDLE, cnt_reg <= $past(cnt_reg), "live count grew during update")
    `ASSERT_ALWAYS(a_pend_only_busy, !pend_valid_reg || busy, "held result outside an update")
    `ASSERT_ALWAYS(a_pos_has_live, !(strobe_reg && (kind_reg == ppu_pkg::KIND_POSITION)) || (live_reg != '0), "position result with empty pool")

endmodule

`default_nettype wire
